// ----- rtl/core/ipv6c_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv6c_pkg
// Types and constants shared by the ipv6 receive classifier and its parts.
// ----------------------------------------------------------------------------
package ipv6c_pkg;

  // protocol constants
  localparam logic [15:0] IPV6_MIN_LEN  = 16'd40;
  localparam logic [3:0]  IP_VERSION    = 4'd6;
  localparam logic [7:0]  NH_TCP        = 8'd6;
  localparam logic [7:0]  NH_UDP        = 8'd17;
  localparam logic [7:0]  NH_ICMP       = 8'd58;
  localparam logic [15:0] ICMP_MIN_LEN  = 16'd4;
  localparam logic [15:0] ND_MIN_LEN    = 16'd32;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd128;
  localparam logic [7:0]  ICMP_NS       = 8'd135;
  localparam logic [7:0]  ICMP_NA       = 8'd136;
  localparam logic [7:0]  MCAST_PREFIX  = 8'hFF;
  localparam logic [63:0] LL_PREFIX     = 64'hFE80_0000_0000_0000;
  localparam logic [15:0] EUI_FILL      = 16'hFFFE;
  localparam logic [7:0]  EUI_UL_BIT    = 8'h02;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ADDR_HIGH = 2'd0,
    CFG_ADDR_LOW  = 2'd1,
    CFG_MAC       = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    V_SHORT       = 4'd0,
    V_BAD_VERSION = 4'd1,
    V_NOT_OURS    = 4'd2,
    V_TCP         = 4'd3,
    V_UDP         = 4'd4,
    V_UNKNOWN     = 4'd5,
    V_ICMP_SHORT  = 4'd6,
    V_ECHO        = 4'd7,
    V_NS_LEARNED  = 4'd8,
    V_NA_LEARNED  = 4'd9,
    V_IGNORED     = 4'd10
  } verdict_e;

  typedef enum logic [1:0] {
    OC_NONE     = 2'd0,
    OC_UPDATED  = 2'd1,
    OC_INSERTED = 2'd2,
    OC_FULL     = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_e;

  // one received packet
  typedef struct packed {
    logic [15:0] frame_len;
    logic [3:0]  version;
    logic [15:0] pld_len;
    logic [7:0]  nxt_hdr;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  icmp_type;
    logic [63:0] target_hi;
    logic [63:0] target_lo;
    logic [47:0] option_mac;
  } in_word_t;

  // one result
  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] delivered_len;
    outcome_e    cache_outcome;
    logic [5:0]  cache_slot;
  } out_word_t;

  // classified packet handed from front to back
  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] dlen;
    logic        learn;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [47:0] mac;
  } job_t;

  // one neighbour cache entry
  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [47:0] link_addr;
  } entry_t;

endpackage

// ----- rtl/core/ipv6c_fifo.sv -----
// ----------------------------------------------------------------------------
// ipv6c_fifo
// Small synchronous queue of words of any packed type.
// ----------------------------------------------------------------------------
module ipv6c_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/ipv6c_front.sv -----
// ----------------------------------------------------------------------------
// ipv6c_front
// Holds the address registers and classifies each incoming word into a job.
// ----------------------------------------------------------------------------
module ipv6c_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  ipv6c_pkg::in_word_t in_word_i,
  output ipv6c_pkg::job_t    job_o
);

  logic [63:0] addr_hi_q;
  logic [63:0] addr_lo_q;
  logic [47:0] mac_q;
  logic [63:0] ll_lo;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_hi_q <= '0;
      addr_lo_q <= '0;
      mac_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipv6c_pkg::CFG_ADDR_HIGH: addr_hi_q <= cfg_wdata_i;
        ipv6c_pkg::CFG_ADDR_LOW:  addr_lo_q <= cfg_wdata_i;
        ipv6c_pkg::CFG_MAC:       mac_q     <= cfg_wdata_i[47:0];
        default: ;
      endcase
    end
  end

  // eui-64 interface id from the mac
  assign ll_lo = {mac_q[47:40] ^ ipv6c_pkg::EUI_UL_BIT, mac_q[39:24],
                  ipv6c_pkg::EUI_FILL, mac_q[23:0]};

  function automatic logic is_ours(input logic [63:0] hi, input logic [63:0] lo,
                                   input logic [63:0] g_hi, input logic [63:0] g_lo,
                                   input logic [63:0] l_lo);
    is_ours = (hi == g_hi && lo == g_lo) || (hi == ipv6c_pkg::LL_PREFIX && lo == l_lo);
  endfunction

  // classification
  always_comb begin
    job_o         = '0;
    job_o.verdict = ipv6c_pkg::V_IGNORED;
    job_o.key_hi  = in_word_i.target_hi;
    job_o.key_lo  = in_word_i.target_lo;
    job_o.mac     = in_word_i.option_mac;
    if (in_word_i.frame_len < ipv6c_pkg::IPV6_MIN_LEN) begin
      job_o.verdict = ipv6c_pkg::V_SHORT;
    end else if (in_word_i.version != ipv6c_pkg::IP_VERSION) begin
      job_o.verdict = ipv6c_pkg::V_BAD_VERSION;
    end else if (!is_ours(in_word_i.dst_addr_hi, in_word_i.dst_addr_lo,
                          addr_hi_q, addr_lo_q, ll_lo) &&
                 in_word_i.dst_addr_hi[63:56] != ipv6c_pkg::MCAST_PREFIX) begin
      job_o.verdict = ipv6c_pkg::V_NOT_OURS;
    end else if (in_word_i.nxt_hdr == ipv6c_pkg::NH_TCP) begin
      job_o.verdict = ipv6c_pkg::V_TCP;
      job_o.dlen    = in_word_i.pld_len;
    end else if (in_word_i.nxt_hdr == ipv6c_pkg::NH_UDP) begin
      job_o.verdict = ipv6c_pkg::V_UDP;
      job_o.dlen    = in_word_i.pld_len;
    end else if (in_word_i.nxt_hdr != ipv6c_pkg::NH_ICMP) begin
      job_o.verdict = ipv6c_pkg::V_UNKNOWN;
    end else if (in_word_i.pld_len < ipv6c_pkg::ICMP_MIN_LEN) begin
      job_o.verdict = ipv6c_pkg::V_ICMP_SHORT;
    end else begin
      job_o.dlen = in_word_i.pld_len;
      if (in_word_i.icmp_type == ipv6c_pkg::ICMP_ECHO_REQ) begin
        job_o.verdict = ipv6c_pkg::V_ECHO;
      end else if (in_word_i.icmp_type == ipv6c_pkg::ICMP_NS) begin
        // solicitation for us teaches the sender
        if (in_word_i.pld_len >= ipv6c_pkg::ND_MIN_LEN &&
            is_ours(in_word_i.target_hi, in_word_i.target_lo,
                    addr_hi_q, addr_lo_q, ll_lo)) begin
          job_o.verdict = ipv6c_pkg::V_NS_LEARNED;
          job_o.learn   = 1'b1;
          job_o.key_hi  = in_word_i.src_addr_hi;
          job_o.key_lo  = in_word_i.src_addr_lo;
        end
      end else if (in_word_i.icmp_type == ipv6c_pkg::ICMP_NA) begin
        // advertisement teaches the target
        if (in_word_i.pld_len >= ipv6c_pkg::ND_MIN_LEN) begin
          job_o.verdict = ipv6c_pkg::V_NA_LEARNED;
          job_o.learn   = 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/ipv6c_back.sv -----
// ----------------------------------------------------------------------------
// ipv6c_back
// Neighbour cache engine: scans the filled entries, then updates, inserts or reports the cache full.
// ----------------------------------------------------------------------------
module ipv6c_back #(
  parameter int CACHE_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_empty_i,
  input  ipv6c_pkg::job_t      job_i,
  output logic                 job_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output ipv6c_pkg::out_word_t res_o
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  ipv6c_pkg::back_state_e state_q, state_d;
  ipv6c_pkg::job_t        job_q;
  ipv6c_pkg::entry_t      mem_q [CACHE_ENTRIES];
  ipv6c_pkg::entry_t      rd_data_q;
  ipv6c_pkg::outcome_e    outcome_q, outcome_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   rd_vld_q;
  logic [CNT_W-1:0]       issue_q;
  logic [CNT_W-1:0]       count_q;
  logic                   rd_en, hit, scan_end, load, mem_we;
  logic [IDX_W+5:0]       slot_ext;

  assign rd_en    = (state_q == ipv6c_pkg::ST_SCAN) && (issue_q < count_q);
  assign hit      = rd_vld_q && rd_data_q.addr_hi == job_q.key_hi &&
                    rd_data_q.addr_lo == job_q.key_lo;
  assign scan_end = !rd_vld_q && (issue_q == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipv6c_pkg::ST_IDLE: begin
        if (!job_empty_i && job_i.learn) begin
          state_d = ipv6c_pkg::ST_SCAN;
        end
      end
      ipv6c_pkg::ST_SCAN: begin
        if (hit || scan_end) begin
          state_d = ipv6c_pkg::ST_DONE;
        end
      end
      ipv6c_pkg::ST_DONE: begin
        if (!res_full_i) begin
          state_d = ipv6c_pkg::ST_IDLE;
        end
      end
      default: state_d = ipv6c_pkg::ST_IDLE;
    endcase
  end

  // outputs and result word
  always_comb begin
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    load       = 1'b0;
    mem_we     = 1'b0;
    slot_ext   = {6'b0, slot_q};
    res_o      = '0;
    case (state_q)
      ipv6c_pkg::ST_IDLE: begin
        // non-learning words go straight out
        res_o.verdict       = job_i.verdict;
        res_o.delivered_len = job_i.dlen;
        res_o.cache_outcome = ipv6c_pkg::OC_NONE;
        if (!job_empty_i) begin
          if (job_i.learn) begin
            job_pop_o = 1'b1;
            load      = 1'b1;
          end else if (!res_full_i) begin
            job_pop_o  = 1'b1;
            res_push_o = 1'b1;
          end
        end
      end
      ipv6c_pkg::ST_DONE: begin
        res_o.verdict       = job_q.verdict;
        res_o.delivered_len = job_q.dlen;
        res_o.cache_outcome = outcome_q;
        res_o.cache_slot    = slot_ext[5:0];
        if (!res_full_i) begin
          res_push_o = 1'b1;
          mem_we     = (outcome_q != ipv6c_pkg::OC_FULL);
        end
      end
      default: ;
    endcase
  end

  // lookup decision
  always_comb begin
    slot_d    = slot_q;
    outcome_d = outcome_q;
    if (state_q == ipv6c_pkg::ST_SCAN) begin
      if (hit) begin
        slot_d    = rd_idx_q;
        outcome_d = ipv6c_pkg::OC_UPDATED;
      end else if (scan_end) begin
        if (count_q < CNT_W'(CACHE_ENTRIES)) begin
          slot_d    = count_q[IDX_W-1:0];
          outcome_d = ipv6c_pkg::OC_INSERTED;
        end else begin
          slot_d    = '0;
          outcome_d = ipv6c_pkg::OC_FULL;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ipv6c_pkg::ST_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      outcome_q <= ipv6c_pkg::OC_NONE;
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      outcome_q <= outcome_d;
      slot_q    <= slot_d;
      rd_vld_q  <= rd_en;
      if (load) begin
        issue_q <= '0;
      end else if (rd_en) begin
        issue_q <= issue_q + 1'b1;
      end
      // entries fill from the bottom and are never removed
      if (mem_we && outcome_q == ipv6c_pkg::OC_INSERTED) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // job holding and read index
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (rd_en) begin
      rd_idx_q <= issue_q[IDX_W-1:0];
    end
  end

  // cache memory
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[issue_q[IDX_W-1:0]];
    end
    if (mem_we) begin
      mem_q[slot_q] <= '{addr_hi: job_q.key_hi, addr_lo: job_q.key_lo, link_addr: job_q.mac};
    end
  end

endmodule

// ----- rtl/core/ipv6_rx_classifier_neighbor_learning.sv -----
// ----------------------------------------------------------------------------
// ipv6_rx_classifier_neighbor_learning
// IPv6 receive filter with a neighbour cache learnt from NS and NA messages.
// ----------------------------------------------------------------------------
//  channel  | handshake         | word
//  ---------+-------------------+-----------------------------------------
//  input    | push_i / full_o   | in_word_i  (ipv6c_pkg::in_word_t)
//  result   | pop_i / empty_o   | out_word_o (ipv6c_pkg::out_word_t)
//  config   | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
// A word that needs no learning passes from the job queue straight into the
// result queue while the back end is idle and the result queue has room. A
// learning word scans the filled cache entries one per cycle through the
// memory read port. Reset empties the cache at once by clearing its fill
// count, with no clearing pass. Two-deep queues sit between front and back
// and on the result side, so input and output stall independently.
module ipv6_rx_classifier_neighbor_learning #(
  parameter int CACHE_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  ipv6c_pkg::in_word_t  in_word_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ipv6c_pkg::out_word_t out_word_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [63:0]          cfg_wdata_i
);

  ipv6c_pkg::job_t      job_in, job_out;
  ipv6c_pkg::out_word_t res_word;
  logic                 job_empty, job_pop, res_full, res_push;

  // classify
  ipv6c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .job_o       (job_in)
  );

  // queue between front and back
  ipv6c_fifo #(
    .DEPTH (2),
    .T     (ipv6c_pkg::job_t)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (job_in),
    .full_o  (full_o),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  // cache engine
  ipv6c_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  // result queue
  ipv6c_fifo #(
    .DEPTH (2),
    .T     (ipv6c_pkg::out_word_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (out_word_o),
    .empty_o (empty_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives IPv6 packet fields into the receive classifier and checks every
// result word against a hand-written result or a local model of the filter and its neighbour cache.
// A fixed list of edge cases is followed by four random phases. Each phase
// uses its own address and MAC setting and its own mix of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ipv6c_pkg::*;

  localparam int NC_ENTRIES   = 64;
  localparam int KEY_POOL     = 80;
  localparam int SETTLE       = NC_ENTRIES + 16;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_WORDS  = 200;

  // directed row: packet plus an optional hand-written result
  typedef struct {
    in_word_t  pkt;
    bit        fixed;
    out_word_t result;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push_i      = 1'b0;
  logic        full_o;
  in_word_t    in_word_i   = '0;
  logic        pop_i       = 1'b0;
  logic        empty_o;
  out_word_t   out_word_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [63:0] cfg_wdata_i = '0;

  // model copy of registers and neighbour cache
  logic [63:0] own_hi  = '0;
  logic [63:0] own_lo  = '0;
  logic [47:0] own_mac = '0;
  logic        nc_valid [NC_ENTRIES];
  logic [63:0] nc_hi    [NC_ENTRIES];
  logic [63:0] nc_lo    [NC_ENTRIES];
  logic [47:0] nc_mac   [NC_ENTRIES];

  logic [127:0] key_pool [KEY_POOL];

  out_word_t verdict_q [$];
  stim_row_t stim_q [$];
  out_word_t predicted, want, got;
  bit        row_fixed = 1'b0;
  out_word_t row_result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int words_in = 0, words_out = 0;
  int n_insert = 0, n_update = 0, n_full = 0;

  ipv6_rx_classifier_neighbor_learning #(
    .CACHE_ENTRIES(NC_ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_word_i  (in_word_i),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // eui-64 interface id from a mac
  function automatic logic [63:0] eui_low(input logic [47:0] m);
    return {m[47:40] ^ EUI_UL_BIT, m[39:24], EUI_FILL, m[23:0]};
  endfunction

  function automatic bit is_own(input logic [63:0] hi, input logic [63:0] lo);
    return (hi == own_hi && lo == own_lo) || (hi == LL_PREFIX && lo == eui_low(own_mac));
  endfunction

  // update a matching entry, else fill the lowest free one
  function automatic outcome_e learn_neighbour(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic [47:0] mac, output logic [5:0] slot);
    for (int i = 0; i < NC_ENTRIES; i++) begin
      if (nc_valid[i] && nc_hi[i] == hi && nc_lo[i] == lo) begin
        nc_mac[i] = mac;
        slot = 6'(i);
        return OC_UPDATED;
      end
    end
    for (int i = 0; i < NC_ENTRIES; i++) begin
      if (!nc_valid[i]) begin
        nc_valid[i] = 1'b1;
        nc_hi[i]    = hi;
        nc_lo[i]    = lo;
        nc_mac[i]   = mac;
        slot = 6'(i);
        return OC_INSERTED;
      end
    end
    slot = '0;
    return OC_FULL;
  endfunction

  // expected result word for one packet, cache updated as a side effect
  function automatic out_word_t classify(input in_word_t p);
    out_word_t  o;
    logic [5:0] slot;
    o.verdict       = V_SHORT;
    o.delivered_len = '0;
    o.cache_outcome = OC_NONE;
    o.cache_slot    = '0;
    if (p.frame_len < IPV6_MIN_LEN) begin
      o.verdict = V_SHORT;
    end else if (p.version != IP_VERSION) begin
      o.verdict = V_BAD_VERSION;
    end else if (!is_own(p.dst_addr_hi, p.dst_addr_lo) &&
                 p.dst_addr_hi[63:56] != MCAST_PREFIX) begin
      o.verdict = V_NOT_OURS;
    end else if (p.nxt_hdr == NH_TCP) begin
      o.verdict = V_TCP;
      o.delivered_len = p.pld_len;
    end else if (p.nxt_hdr == NH_UDP) begin
      o.verdict = V_UDP;
      o.delivered_len = p.pld_len;
    end else if (p.nxt_hdr != NH_ICMP) begin
      o.verdict = V_UNKNOWN;
    end else if (p.pld_len < ICMP_MIN_LEN) begin
      o.verdict = V_ICMP_SHORT;
    end else begin
      o.delivered_len = p.pld_len;
      o.verdict = V_IGNORED;
      if (p.icmp_type == ICMP_ECHO_REQ) begin
        o.verdict = V_ECHO;
      end else if (p.icmp_type == ICMP_NS) begin
        if (p.pld_len >= ND_MIN_LEN && is_own(p.target_hi, p.target_lo)) begin
          o.cache_outcome = learn_neighbour(p.src_addr_hi, p.src_addr_lo, p.option_mac, slot);
          o.cache_slot = slot;
          o.verdict = V_NS_LEARNED;
        end
      end else if (p.icmp_type == ICMP_NA) begin
        if (p.pld_len >= ND_MIN_LEN) begin
          o.cache_outcome = learn_neighbour(p.target_hi, p.target_lo, p.option_mac, slot);
          o.cache_slot = slot;
          o.verdict = V_NA_LEARNED;
        end
      end
    end
    return o;
  endfunction

  // one of our two addresses
  function automatic logic [127:0] own_addr();
    if ($urandom_range(1) == 0) return {own_hi, own_lo};
    return {LL_PREFIX, eui_low(own_mac)};
  endfunction

  // mostly neighbours already seen, now and then a fresh one
  function automatic logic [127:0] pick_key();
    if ($urandom_range(99) < 90) return key_pool[$urandom_range(KEY_POOL - 1)];
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic bit sender_idles();
    return $urandom_range(99) < send_idle_pct;
  endfunction

  // accepted input words: predict and queue
  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o) begin
      predicted = classify(in_word_i);
      case (predicted.cache_outcome)
        OC_INSERTED: n_insert++;
        OC_UPDATED:  n_update++;
        OC_FULL:     n_full++;
        default: ;
      endcase
      if (row_fixed) verdict_q.push_back(row_result);
      else verdict_q.push_back(predicted);
      words_in++;
    end
  end

  // accepted result words: compare with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      words_out++;
      if (verdict_q.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        got  = out_word_o;
        if (got.verdict !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
          errors++;
        end
        if (got.delivered_len !== want.delivered_len) begin
          $error("delivered_len: expected %0h, actual %0h",
                 want.delivered_len, got.delivered_len);
          errors++;
        end
        if (got.cache_outcome !== want.cache_outcome) begin
          $error("cache_outcome: expected %0d, actual %0d",
                 want.cache_outcome, got.cache_outcome);
          errors++;
        end
        if (got.cache_slot !== want.cache_slot) begin
          $error("cache_slot: expected %0d, actual %0d", want.cache_slot, got.cache_slot);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    pop_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // entered and left at a falling edge; push stays high for a back-to-back word
  task automatic send_word(input in_word_t w);
    while (sender_idles()) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i    <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_ADDR_HIGH: own_hi  = val;
      CFG_ADDR_LOW:  own_lo  = val;
      CFG_MAC:       own_mac = val[47:0];
      default: ;
    endcase
  endtask

  // wait for every result, then let the back end go quiet
  task automatic settle();
    push_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic add_row(input in_word_t w, input bit fixed, input verdict_e v,
                         input logic [15:0] dlen, input outcome_e oc, input logic [5:0] slot);
    stim_row_t r;
    r.pkt = w;
    r.fixed = fixed;
    r.result.verdict       = v;
    r.result.delivered_len = dlen;
    r.result.cache_outcome = oc;
    r.result.cache_slot    = slot;
    stim_q.push_back(r);
  endtask

  // random packets, mostly well formed and addressed to us
  task automatic run_phase(input int n, input int send_pct, input int recv_pct);
    in_word_t     p;
    logic [127:0] k;
    int           r;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) begin
      p.src_addr_hi = {$urandom, $urandom};
      p.src_addr_lo = {$urandom, $urandom};
      p.target_hi   = {$urandom, $urandom};
      p.target_lo   = {$urandom, $urandom};
      p.option_mac  = {16'($urandom), $urandom};
      r = $urandom_range(99);
      if (r < 6) p.frame_len = 16'($urandom_range(39));
      else if (r < 12) p.frame_len = IPV6_MIN_LEN;
      else p.frame_len = 16'($urandom);
      p.version = ($urandom_range(99) < 8) ? 4'($urandom) : IP_VERSION;
      r = $urandom_range(99);
      if (r < 40) begin
        k = own_addr();
      end else if (r < 80) begin
        k = {$urandom, $urandom, $urandom, $urandom};
        k[127:120] = MCAST_PREFIX;
      end else begin
        k = {$urandom, $urandom, $urandom, $urandom};
      end
      {p.dst_addr_hi, p.dst_addr_lo} = k;
      r = $urandom_range(99);
      if (r < 8) p.nxt_hdr = NH_TCP;
      else if (r < 16) p.nxt_hdr = NH_UDP;
      else if (r < 24) p.nxt_hdr = 8'($urandom);
      else p.nxt_hdr = NH_ICMP;
      r = $urandom_range(99);
      if (r < 8) p.pld_len = 16'($urandom_range(3));
      else if (r < 16) p.pld_len = 16'($urandom_range(31, 4));
      else if (r < 22) p.pld_len = ND_MIN_LEN;
      else p.pld_len = 16'($urandom);
      r = $urandom_range(99);
      if (r < 12) p.icmp_type = ICMP_ECHO_REQ;
      else if (r < 50) p.icmp_type = ICMP_NS;
      else if (r < 88) p.icmp_type = ICMP_NA;
      else p.icmp_type = 8'($urandom);
      if (p.icmp_type == ICMP_NS) begin
        {p.src_addr_hi, p.src_addr_lo} = pick_key();
        if ($urandom_range(99) < 85) {p.target_hi, p.target_lo} = own_addr();
      end else if (p.icmp_type == ICMP_NA) begin
        {p.target_hi, p.target_lo} = pick_key();
      end
      send_word(p);
    end
    settle();
  endtask

  initial begin
    in_word_t    base, w;
    logic [63:0] ll_lo;
    logic [63:0] a_hi, a_lo, b_hi, b_lo;
    for (int i = 0; i < NC_ENTRIES; i++) nc_valid[i] = 1'b0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom, $urandom, $urandom};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // edge cases with the reset register values: own address is all zero
    ll_lo = eui_low(48'h0);
    a_hi = 64'h2001_0db8_0000_0001;
    a_lo = 64'h0000_0000_0000_00a1;
    b_hi = 64'h2001_0db8_0000_0002;
    b_lo = 64'h0000_0000_0000_00b2;
    base = '0;
    base.frame_len   = 16'd60;
    base.version     = IP_VERSION;
    base.pld_len     = ND_MIN_LEN;
    base.nxt_hdr     = NH_ICMP;
    base.src_addr_hi = a_hi;
    base.src_addr_lo = a_lo;
    base.icmp_type   = ICMP_NA;
    base.target_hi   = b_hi;
    base.target_lo   = b_lo;
    base.option_mac  = 48'h0200_1122_3344;

    w = base; w.frame_len = 16'd0;
    add_row(w, 1'b1, V_SHORT, 16'd0, OC_NONE, 6'd0);
    w = base; w.frame_len = 16'd39; w.version = 4'hF;
    add_row(w, 1'b1, V_SHORT, 16'd0, OC_NONE, 6'd0);
    w = base; w.frame_len = IPV6_MIN_LEN; w.version = 4'h0;
    add_row(w, 1'b1, V_BAD_VERSION, 16'd0, OC_NONE, 6'd0);
    w = base; w.version = 4'hF;
    add_row(w, 1'b1, V_BAD_VERSION, 16'd0, OC_NONE, 6'd0);
    w = base; w.dst_addr_hi = a_hi; w.nxt_hdr = NH_TCP;
    add_row(w, 1'b1, V_NOT_OURS, 16'd0, OC_NONE, 6'd0);
    w = base; w.dst_addr_hi = 64'hFF02_0000_0000_0000; w.dst_addr_lo = 64'd1;
    w.nxt_hdr = NH_TCP; w.frame_len = 16'hFFFF; w.pld_len = 16'hFFFF;
    add_row(w, 1'b1, V_TCP, 16'hFFFF, OC_NONE, 6'd0);
    w = base; w.dst_addr_hi = LL_PREFIX; w.dst_addr_lo = ll_lo;
    w.nxt_hdr = NH_UDP; w.pld_len = 16'd0;
    add_row(w, 1'b1, V_UDP, 16'd0, OC_NONE, 6'd0);
    w = base; w.nxt_hdr = 8'h00;
    add_row(w, 1'b1, V_UNKNOWN, 16'd0, OC_NONE, 6'd0);
    w = base; w.nxt_hdr = 8'hFF;
    add_row(w, 1'b1, V_UNKNOWN, 16'd0, OC_NONE, 6'd0);
    // icmp shorter than its header
    w = base; w.pld_len = 16'd3;
    add_row(w, 1'b1, V_ICMP_SHORT, 16'd0, OC_NONE, 6'd0);
    w = base; w.pld_len = ICMP_MIN_LEN; w.icmp_type = ICMP_ECHO_REQ;
    add_row(w, 1'b1, V_ECHO, ICMP_MIN_LEN, OC_NONE, 6'd0);
    // other icmp types are passed on untouched
    w = base; w.icmp_type = 8'h00; w.pld_len = 16'hFFFF;
    add_row(w, 1'b1, V_IGNORED, 16'hFFFF, OC_NONE, 6'd0);
    w = base; w.icmp_type = 8'hFF;
    add_row(w, 1'b1, V_IGNORED, ND_MIN_LEN, OC_NONE, 6'd0);
    // solicitation too short, then aimed at someone else
    w = base; w.icmp_type = ICMP_NS; w.pld_len = 16'd31; w.target_hi = '0; w.target_lo = '0;
    add_row(w, 1'b1, V_IGNORED, 16'd31, OC_NONE, 6'd0);
    w = base; w.icmp_type = ICMP_NS;
    add_row(w, 1'b1, V_IGNORED, ND_MIN_LEN, OC_NONE, 6'd0);
    // solicitation for our global and then our link-local address
    w = base; w.icmp_type = ICMP_NS; w.target_hi = '0; w.target_lo = '0;
    add_row(w, 1'b1, V_NS_LEARNED, ND_MIN_LEN, OC_INSERTED, 6'd0);
    w = base; w.icmp_type = ICMP_NS; w.target_hi = LL_PREFIX; w.target_lo = ll_lo;
    w.option_mac = 48'h0aff_eedd_ccbb;
    add_row(w, 1'b1, V_NS_LEARNED, ND_MIN_LEN, OC_UPDATED, 6'd0);
    // advertisements
    w = base; w.pld_len = 16'd31;
    add_row(w, 1'b1, V_IGNORED, 16'd31, OC_NONE, 6'd0);
    w = base;
    add_row(w, 1'b1, V_NA_LEARNED, ND_MIN_LEN, OC_INSERTED, 6'd1);
    w = base; w.target_hi = a_hi; w.target_lo = a_lo;
    add_row(w, 1'b1, V_NA_LEARNED, ND_MIN_LEN, OC_UPDATED, 6'd0);
    w = base; w.target_hi = '1; w.target_lo = '1; w.option_mac = '1; w.pld_len = 16'hFFFF;
    add_row(w, 1'b1, V_NA_LEARNED, 16'hFFFF, OC_INSERTED, 6'd2);
    // all-ones sender to a multicast destination, left to the model
    w = base; w.icmp_type = ICMP_NS; w.src_addr_hi = '1; w.src_addr_lo = '1;
    w.target_hi = '0; w.target_lo = '0; w.dst_addr_hi = '1; w.dst_addr_lo = '1;
    w.frame_len = 16'hFFFF; w.pld_len = 16'd40; w.option_mac = 48'h0;
    add_row(w, 1'b0, V_SHORT, 16'd0, OC_NONE, 6'd0);
    // payload length larger than the frame itself
    w = base; w.frame_len = IPV6_MIN_LEN; w.pld_len = 16'hFFFF;
    w.target_hi = {$urandom, $urandom}; w.target_lo = {$urandom, $urandom};
    add_row(w, 1'b0, V_SHORT, 16'd0, OC_NONE, 6'd0);

    foreach (stim_q[i]) begin
      row_fixed  = stim_q[i].fixed;
      row_result = stim_q[i].result;
      send_word(stim_q[i].pkt);
    end
    row_fixed = 1'b0;
    settle();

    // random setting, no idling
    write_reg(CFG_ADDR_HIGH, {$urandom, $urandom});
    write_reg(CFG_ADDR_LOW, {$urandom, $urandom});
    write_reg(CFG_MAC, {$urandom, $urandom});
    run_phase(PHASE_WORDS, 0, 0);

    // all ones, sparse sender
    write_reg(CFG_ADDR_HIGH, '1);
    write_reg(CFG_ADDR_LOW, '1);
    write_reg(CFG_MAC, '1);
    run_phase(PHASE_WORDS, 85, 0);

    // all zeros, slow receiver
    write_reg(CFG_ADDR_HIGH, '0);
    write_reg(CFG_ADDR_LOW, '0);
    write_reg(CFG_MAC, '0);
    run_phase(PHASE_WORDS, 0, 85);

    // random again, both sides idling
    write_reg(CFG_ADDR_HIGH, {$urandom, $urandom});
    write_reg(CFG_ADDR_LOW, {$urandom, $urandom});
    write_reg(CFG_MAC, {$urandom, $urandom});
    run_phase(PHASE_WORDS, 36, 36);

    $display("summary: %0d packets in, %0d result words checked, four register settings",
             words_in, words_out);
    $display("summary: neighbour cache saw %0d inserts, %0d updates, %0d refused when full",
             n_insert, n_update, n_full);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ipv6c_pkg.sv
rtl/core/ipv6c_fifo.sv
rtl/core/ipv6c_front.sv
rtl/core/ipv6c_back.sv
rtl/core/ipv6_rx_classifier_neighbor_learning.sv
tb/testbench.sv
